// ===== src/wpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Warm-up phase gate package
// Widths, register indexes, opcodes and gate codes shared by the block.
// ----------------------------------------------------------------------------
package wpg_pkg;

    localparam int TIME_W  = 40;
    localparam int CNT_W   = 32;
    localparam int ALPHA_W = 16;
    localparam int RES_W   = 20;
    localparam int BSZ_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 40;
    localparam int GATE_W  = 3;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_BATCH  = 2'd0;
    localparam logic [OP_W-1:0] OP_CPU    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESULT = 2'd2;
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CPU  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BAT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RES  = 3'd5;

    localparam logic [GATE_W-1:0] GATE_TIME = 3'd0;
    localparam logic [GATE_W-1:0] GATE_CPU  = 3'd1;
    localparam logic [GATE_W-1:0] GATE_BAT  = 3'd2;
    localparam logic [GATE_W-1:0] GATE_PIPE = 3'd3;
    localparam logic [GATE_W-1:0] GATE_NONE = 3'd4;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;
    localparam logic [TIME_W-1:0]  BOOT_RESET  = 40'd3600000;

endpackage

// ===== src/wpg_in_if.sv =====
// ----------------------------------------------------------------------------
// Event channel
// Valid/ready channel that carries one scheduler event item.
// ----------------------------------------------------------------------------
interface wpg_in_if;
    import wpg_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [TIME_W-1:0]   now_time;
    logic [CNT_W-1:0]    budget;
    logic [CNT_W-1:0]    placed_work;
    logic [BSZ_W-1:0]    batch_jobs;
    logic [CNT_W-1:0]    cpu_time;
    logic [TIME_W-1:0]   dispatch_time;
    logic [RES_W-1:0]    current_results;

    modport source (output valid, opcode, now_time, budget, placed_work, batch_jobs,
                    cpu_time, dispatch_time, current_results, input ready);
    modport sink (input valid, opcode, now_time, budget, placed_work, batch_jobs,
                  cpu_time, dispatch_time, current_results, output ready);
endinterface

// ===== src/wpg_out_if.sv =====
// ----------------------------------------------------------------------------
// Status channel
// Valid/ready channel that carries one status item per event.
// ----------------------------------------------------------------------------
interface wpg_out_if;
    import wpg_pkg::*;

    logic                valid;
    logic                ready;
    logic                steady_phase;
    logic [GATE_W-1:0]   limiting_gate;
    logic [TIME_W-1:0]   steady_started_at;
    logic [CNT_W-1:0]    avg_cpu;
    logic [TIME_W-1:0]   avg_turnaround;
    logic [CNT_W-1:0]    avg_fill;
    logic                cpu_estimate_valid;
    logic [CNT_W-1:0]    batch_count;
    logic [CNT_W-1:0]    cpu_sample_count;
    logic [CNT_W-1:0]    result_sample_count;
    logic                event_taken;

    modport source (output valid, steady_phase, limiting_gate, steady_started_at,
                    avg_cpu, avg_turnaround, avg_fill, cpu_estimate_valid,
                    batch_count, cpu_sample_count, result_sample_count,
                    event_taken, input ready);
    modport sink (input valid, steady_phase, limiting_gate, steady_started_at,
                  avg_cpu, avg_turnaround, avg_fill, cpu_estimate_valid,
                  batch_count, cpu_sample_count, result_sample_count,
                  event_taken, output ready);
endinterface

// ===== src/wpg_div.sv =====
// ----------------------------------------------------------------------------
// Fill ratio divider
// Bit-serial restoring divider: floor(placed work * 65536 / budget), one
// quotient bit per cycle, saturated to 32 bits.
// ----------------------------------------------------------------------------
module wpg_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wpg_pkg::CNT_W-1:0] i_placed,
    input  logic [wpg_pkg::CNT_W-1:0] i_budget,
    output logic                      o_done,
    output logic [wpg_pkg::CNT_W-1:0] o_ratio
);
    import wpg_pkg::*;

    localparam int DVD_W = CNT_W + 16;
    localparam int CNT_BITS = $clog2(DVD_W);

    logic                r_busy, r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DVD_W-1:0]    r_dvd, r_q;
    logic [CNT_W-1:0]    r_rem, r_dvs;
    logic [CNT_W:0]      w_trial;
    logic                w_ge;

    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_placed, 16'd0};
            r_dvs <= i_budget;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_q   <= {r_q[DVD_W-2:0], w_ge};
            r_rem <= w_ge ? CNT_W'(w_trial - {1'b0, r_dvs}) : w_trial[CNT_W-1:0];
        end
    end

    assign o_done  = r_done;
    assign o_ratio = (|r_q[DVD_W-1:CNT_W]) ? '1 : r_q[CNT_W-1:0];
endmodule

// ===== src/wpg_ema.sv =====
// ----------------------------------------------------------------------------
// Moving average unit
// Serial shift-add update avg + round(alpha * (sample - avg) / 65536), one
// alpha bit per cycle; a zero average is seeded by the sample.
// ----------------------------------------------------------------------------
module wpg_ema (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [wpg_pkg::ALPHA_W-1:0] i_alpha,
    input  logic [wpg_pkg::TIME_W-1:0]  i_avg,
    input  logic [wpg_pkg::TIME_W-1:0]  i_sample,
    output logic                        o_done,
    output logic [wpg_pkg::TIME_W-1:0]  o_result
);
    import wpg_pkg::*;

    localparam int ACC_W = TIME_W + ALPHA_W + 2;
    localparam int CNT_BITS = $clog2(ALPHA_W);

    logic                     r_busy, r_done, r_seed;
    logic [CNT_BITS-1:0]      r_cnt;
    logic [ALPHA_W-1:0]       r_alpha;
    logic signed [ACC_W-1:0]  r_d, r_acc;
    logic [TIME_W-1:0]        r_avg, r_sample;
    logic signed [ACC_W-1:0]  w_rnd, w_sum;

    assign w_rnd = (r_acc + ACC_W'(32768)) >>> ALPHA_W;
    assign w_sum = $signed({{(ACC_W-TIME_W){1'b0}}, r_avg}) + w_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(ALPHA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_alpha  <= i_alpha;
            r_avg    <= i_avg;
            r_sample <= i_sample;
            r_seed   <= (i_avg == '0);
            r_acc    <= '0;
            r_d      <= $signed({{(ACC_W-TIME_W){1'b0}}, i_sample})
                      - $signed({{(ACC_W-TIME_W){1'b0}}, i_avg});
        end else if (r_busy) begin
            if (r_alpha[0]) begin
                r_acc <= r_acc + r_d;
            end
            r_d     <= r_d <<< 1;
            r_alpha <= r_alpha >> 1;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_seed ? r_sample : w_sum[TIME_W-1:0];
endmodule

// ===== src/warmup_phase_gate_with_ema.sv =====
// ----------------------------------------------------------------------------
// Warm-up phase gate with moving averages
// Tracks scheduler events, three moving averages and the warm-up gates.
// ----------------------------------------------------------------------------
// Each event item on i_in yields exactly one status item on o_out. Register
// writes on the i_cfg port take effect at the next clock edge. The user must
// make them only while no event is in flight; the block does not enforce it.
// An event is accepted only in the idle state. An ignored or rejected event
// goes straight to the status state; a phase check or a batch without a fill
// ratio passes the gate check first; a cpu or turnaround sample passes the
// serial multiply of the average unit and then the gate check; a batch with
// a fill ratio passes the divider, the average unit and the gate check.
// The next event is accepted once the last status item has been loaded. One
// event is processed at a time.
// Reset clears all counters, averages and gate times, selects bootstrap
// phase, sets the limiting gate to unknown and loads the register defaults.
// While the receiver stalls, the status item holds on o_out and the next
// event is processed up to its own status, where it waits.
// ----------------------------------------------------------------------------
module warmup_phase_gate_with_ema (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wpg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wpg_pkg::CFG_DAT_W-1:0] i_cfg_data,
    wpg_in_if.sink                        i_in,
    wpg_out_if.source                     o_out
);
    import wpg_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_EMA   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]          r_state;
    logic                r_fb;
    logic [ALPHA_W-1:0]  r_alpha;
    logic [TIME_W-1:0]   r_boot;
    logic [CNT_W-1:0]    r_min_cpu, r_min_bat;
    logic [RES_W-1:0]    r_min_res;

    logic                r_steady;
    logic [CNT_W-1:0]    r_bat_cnt, r_cpu_cnt, r_res_cnt;
    logic [CNT_W-1:0]    r_avg_cpu, r_avg_fill;
    logic [TIME_W-1:0]   r_avg_turn;
    logic [TIME_W-1:0]   r_gate_t [4];
    logic [3:0]          r_gate_f;
    logic [TIME_W-1:0]   r_start_t;
    logic [GATE_W-1:0]   r_lim;
    logic                r_chg;

    logic [OP_W-1:0]     r_op;
    logic [TIME_W-1:0]   r_now;
    logic [RES_W-1:0]    r_res;

    logic                w_acc;
    logic [OP_W-1:0]     w_op;
    logic                w_cnt_up;
    logic                w_out_load;
    logic                w_div_done, w_ema_done, w_ema_start;
    logic [CNT_W-1:0]    w_ratio;
    logic [TIME_W-1:0]   w_ema_res, w_ema_avg, w_ema_smp;
    logic [3:0]          w_ok, w_new;
    logic [TIME_W-1:0]   w_t [4];
    logic [GATE_W-1:0]   w_best;
    logic [TIME_W-1:0]   w_bt;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc = i_in.valid && i_in.ready;
    assign w_op  = w_acc ? i_in.opcode : r_op;
    assign w_out_load = (r_state == S_OUT) && (!o_out.valid || o_out.ready);

    assign w_ema_start = (w_acc && r_fb
                          && ((i_in.opcode == OP_CPU && i_in.cpu_time != '0)
                              || (i_in.opcode == OP_RESULT
                                  && i_in.now_time > i_in.dispatch_time)))
                         || (r_state == S_DIV && w_div_done);

    always_comb begin
        case (i_in.opcode)
            OP_BATCH:  w_cnt_up = i_in.batch_jobs != '0 && r_bat_cnt != '1;
            OP_CPU:    w_cnt_up = i_in.cpu_time != '0 && r_cpu_cnt != '1;
            OP_RESULT: w_cnt_up = i_in.now_time > i_in.dispatch_time && r_res_cnt != '1;
            default:   w_cnt_up = 1'b0;
        endcase
    end

    always_comb begin
        case (w_op)
            OP_CPU: begin
                w_ema_avg = TIME_W'(r_avg_cpu);
                w_ema_smp = TIME_W'(i_in.cpu_time);
            end
            OP_RESULT: begin
                w_ema_avg = r_avg_turn;
                w_ema_smp = i_in.now_time - i_in.dispatch_time;
            end
            default: begin
                w_ema_avg = TIME_W'(r_avg_fill);
                w_ema_smp = TIME_W'(w_ratio);
            end
        endcase
    end

    wpg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_acc && r_fb && i_in.opcode == OP_BATCH
                     && i_in.budget != '0 && i_in.placed_work != '0),
        .i_placed   (i_in.placed_work),
        .i_budget   (i_in.budget),
        .o_done     (w_div_done),
        .o_ratio    (w_ratio)
    );

    wpg_ema u_ema (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_ema_start),
        .i_alpha  (r_alpha),
        .i_avg    (w_ema_avg),
        .i_sample (w_ema_smp),
        .o_done   (w_ema_done),
        .o_result (w_ema_res)
    );

    always_comb begin
        w_ok[0] = r_now >= r_boot;
        w_ok[1] = r_cpu_cnt >= r_min_cpu;
        w_ok[2] = r_bat_cnt >= r_min_bat;
        w_ok[3] = r_res >= r_min_res;
        for (int i = 0; i < 4; i++) begin
            w_new[i] = w_ok[i] && !r_gate_f[i];
            w_t[i]   = w_new[i] ? r_now : r_gate_t[i];
        end
        w_best = GATE_TIME;
        w_bt   = w_t[0];
        if (w_t[1] > w_bt) begin
            w_best = GATE_CPU;
            w_bt   = w_t[1];
        end
        if (w_t[2] > w_bt) begin
            w_best = GATE_BAT;
            w_bt   = w_t[2];
        end
        if (w_t[3] > w_bt) begin
            w_best = GATE_PIPE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb      <= 1'b1;
            r_alpha   <= ALPHA_RESET;
            r_boot    <= BOOT_RESET;
            r_min_cpu <= CNT_W'(1);
            r_min_bat <= CNT_W'(1);
            r_min_res <= RES_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FEEDBACK: r_fb      <= i_cfg_data[0];
                CFG_ALPHA:    r_alpha   <= i_cfg_data[ALPHA_W-1:0];
                CFG_BOOT:     r_boot    <= i_cfg_data[TIME_W-1:0];
                CFG_MIN_CPU:  r_min_cpu <= i_cfg_data[CNT_W-1:0];
                CFG_MIN_BAT:  r_min_bat <= i_cfg_data[CNT_W-1:0];
                CFG_MIN_RES:  r_min_res <= i_cfg_data[RES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op  <= i_in.opcode;
            r_now <= i_in.now_time;
            r_res <= i_in.current_results;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out.valid <= 1'b0;
        end else if (w_out_load) begin
            o_out.valid <= 1'b1;
        end else if (o_out.ready) begin
            o_out.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_steady    <= 1'b0;
            r_bat_cnt   <= '0;
            r_cpu_cnt   <= '0;
            r_res_cnt   <= '0;
            r_avg_cpu   <= '0;
            r_avg_turn  <= '0;
            r_avg_fill  <= '0;
            r_gate_f    <= '0;
            r_start_t   <= '0;
            r_lim       <= GATE_NONE;
            r_chg       <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_gate_t[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_chg <= r_fb && w_cnt_up;
                        if (!r_fb) begin
                            r_state <= S_OUT;
                        end else begin
                            case (i_in.opcode)
                                OP_BATCH: begin
                                    if (i_in.batch_jobs != '0 && r_bat_cnt != '1) begin
                                        r_bat_cnt <= r_bat_cnt + 1'b1;
                                    end
                                    if (i_in.budget != '0 && i_in.placed_work != '0) begin
                                        r_state <= S_DIV;
                                    end else begin
                                        r_state <= S_CHECK;
                                    end
                                end
                                OP_CPU: begin
                                    if (i_in.cpu_time != '0) begin
                                        if (r_cpu_cnt != '1) begin
                                            r_cpu_cnt <= r_cpu_cnt + 1'b1;
                                        end
                                        r_state <= S_EMA;
                                    end else begin
                                        r_state <= S_OUT;
                                    end
                                end
                                OP_RESULT: begin
                                    if (i_in.now_time > i_in.dispatch_time) begin
                                        if (r_res_cnt != '1) begin
                                            r_res_cnt <= r_res_cnt + 1'b1;
                                        end
                                        r_state <= S_EMA;
                                    end else begin
                                        r_state <= S_OUT;
                                    end
                                end
                                default: r_state <= S_CHECK;
                            endcase
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_EMA;
                    end
                end
                S_EMA: begin
                    if (w_ema_done) begin
                        case (r_op)
                            OP_CPU: begin
                                r_avg_cpu <= w_ema_res[CNT_W-1:0];
                                if (w_ema_res[CNT_W-1:0] != r_avg_cpu) r_chg <= 1'b1;
                            end
                            OP_RESULT: begin
                                r_avg_turn <= w_ema_res;
                                if (w_ema_res != r_avg_turn) r_chg <= 1'b1;
                            end
                            default: begin
                                r_avg_fill <= w_ema_res[CNT_W-1:0];
                                if (w_ema_res[CNT_W-1:0] != r_avg_fill) r_chg <= 1'b1;
                            end
                        endcase
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!r_steady) begin
                        for (int i = 0; i < 4; i++) begin
                            r_gate_t[i] <= w_t[i];
                        end
                        r_gate_f <= r_gate_f | w_new;
                        if (|w_new || &w_ok) begin
                            r_chg <= 1'b1;
                        end
                        if (&w_ok) begin
                            r_steady  <= 1'b1;
                            r_start_t <= r_now;
                            r_lim     <= w_best;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_out.steady_phase        <= !r_fb || r_steady;
            o_out.limiting_gate       <= r_lim;
            o_out.steady_started_at   <= r_start_t;
            o_out.avg_cpu             <= r_avg_cpu;
            o_out.avg_turnaround      <= r_avg_turn;
            o_out.avg_fill            <= r_avg_fill;
            o_out.cpu_estimate_valid  <= r_fb && r_cpu_cnt != '0 && r_avg_cpu != '0;
            o_out.batch_count         <= r_bat_cnt;
            o_out.cpu_sample_count    <= r_cpu_cnt;
            o_out.result_sample_count <= r_res_cnt;
            o_out.event_taken         <= r_fb && r_chg;
        end
    end
endmodule
